/* sv/max_pool_with_argmax_routing_core_assert.svh */
// Assertion macros for the checker file of the max pool core.
`ifndef MAX_POOL_WITH_ARGMAX_ROUTING_CORE_ASSERT_SVH
`define MAX_POOL_WITH_ARGMAX_ROUTING_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define MPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("max pool core: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define MPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("max pool core: same-cycle check failed");

// Checked also while reset is high.
`define MPA_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("max pool core: reset check failed");

`endif

/* sv/mpa_pkg.sv */
// Shared constants, types and helpers of the max pool with argmax core.
package mpa_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_MAPS   = 16;
   localparam int HALF_W     = MAX_WIDTH / 2;
   localparam int HALF_H     = MAX_HEIGHT / 2;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int MAP_W  = $clog2(MAX_MAPS);
   localparam int PCOL_W = $clog2(HALF_W);
   localparam int PROW_W = $clog2(HALF_H);
   localparam int POS_AW = MAP_W + PROW_W + PCOL_W;

   // Field widths of the registers and items.
   localparam int DIM_W      = 9;
   localparam int MAPS_W     = 5;
   localparam int VALUE_W    = 16;
   localparam int POS_CODE_W = 3;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MAP_COUNT    = 2'd2;

   localparam logic KIND_FWD = 1'b0;
   localparam logic KIND_BWD = 1'b1;

   // Window position codes: none, then top-left .. bottom-right.
   localparam logic [POS_CODE_W-1:0] POS_NONE = 3'd0;
   localparam logic [1:0] WP_TOP_LEFT  = 2'd0;
   localparam logic [1:0] WP_TOP_RIGHT = 2'd1;
   localparam logic [1:0] WP_BOT_LEFT  = 2'd2;
   localparam logic [1:0] WP_BOT_RIGHT = 2'd3;

   localparam logic [DIM_W-1:0]  DIM_MIN  = DIM_W'(2);
   localparam logic [DIM_W-1:0]  WIDTH_MAX  = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0]  HEIGHT_MAX = DIM_W'(MAX_HEIGHT);
   localparam logic [MAPS_W-1:0] MAPS_MIN = MAPS_W'(1);
   localparam logic [MAPS_W-1:0] MAPS_MAX = MAPS_W'(MAX_MAPS);

   // Clamped configuration as the datapath uses it.
   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [MAPS_W-1:0] maps;
   } cfg_type;

   // Forward item as it sits in the input stage.
   typedef struct packed {
      logic                      ok;
      logic [1:0]                wpos;
      logic [PCOL_W-1:0]         wcol;
      logic signed [VALUE_W-1:0] value;
   } fwd_item_type;

   // Running maximum with its position code.
   typedef struct packed {
      logic signed [VALUE_W-1:0] maxv;
      logic [POS_CODE_W-1:0]     pos;
   } win_entry_type;

   // Window outcome for a completed window.
   typedef struct packed {
      logic [POS_CODE_W-1:0]     pos;
      logic signed [VALUE_W-1:0] pooled;
   } win_res_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      r = v;
      if (v < DIM_MIN) r = DIM_MIN;
      else if (v > hi) r = hi;
      return r;
   endfunction

   function automatic logic [MAPS_W-1:0] clamp_maps(input logic [MAPS_W-1:0] v);
      logic [MAPS_W-1:0] r;
      r = v;
      if (v < MAPS_MIN) r = MAPS_MIN;
      else if (v > MAPS_MAX) r = MAPS_MAX;
      return r;
   endfunction

   // Strict update of a running maximum by one sample.
   function automatic win_entry_type win_update(input win_entry_type e,
                                                input logic signed [VALUE_W-1:0] v,
                                                input logic [1:0] wp);
      win_entry_type r;
      r = e;
      if (v > e.maxv) begin
         r.maxv = v;
         r.pos  = {1'b0, wp} + POS_CODE_W'(1);
      end
      return r;
   endfunction

endpackage

/* sv/mpa_chan_if.sv */
// Valid/ready channel interfaces for the request and response sides.
interface mpa_req_if;
   import mpa_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic signed [VALUE_W-1:0] value;
   modport source (output valid, kind, value, input ready);
   modport sink   (input valid, kind, value, output ready);
endinterface

interface mpa_rsp_if;
   import mpa_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      result_kind;
   logic signed [VALUE_W-1:0] result_value;
   logic                      last_of_run;
   modport source (output valid, result_kind, result_value, last_of_run, input ready);
   modport sink   (input valid, result_kind, result_value, last_of_run, output ready);
endinterface

/* sv/max_pool_with_argmax_routing_core.sv */
// Top level of the 2x2 max pool core with argmax gradient routing.
//
//   channel   direction  handshake            payload
//   req_chan  in         valid/ready          kind, value
//   rsp_chan  out        valid/ready          result_kind, result_value, last_of_run
//   APB       in         psel/penable/pready  paddr, pwdata, prdata
//
// A forward sample is taken every cycle unless the input register is held; it
// passes the input register and, at a window's bottom right sample, one pooled
// value goes to the result register. A backward error gives four gradients, one
// per cycle while rsp is ready; the single result register is held to the last.
// Reset is synchronous, sets the configuration registers to their defaults and
// clears the counters and stage valid flags, not the window or position stores.
// Items that give no result keep moving while a result waits for rsp ready; an
// item that gives one holds the input register until the result register frees.
module max_pool_with_argmax_routing_core (
   input  logic                            clock,
   input  logic                            reset,
   mpa_req_if.sink                         req_chan,
   mpa_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mpa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [mpa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [mpa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import mpa_pkg::*;

   cfg_type cfg;

   mpa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic [DIM_W-1:0] pool_w, pool_h;
   assign pool_w = {1'b0, cfg.width[DIM_W-1:1]};
   assign pool_h = {1'b0, cfg.height[DIM_W-1:1]};

   // Counters.
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [MAP_W-1:0]  map_ff, map_in;
   logic [PCOL_W-1:0] bcol_ff, bcol_in;
   logic [PROW_W-1:0] brow_ff, brow_in;
   logic [MAP_W-1:0]  bmap_ff, bmap_in;

   // Input stage.
   logic                      in_v_ff;
   logic                      in_kind_ff;
   fwd_item_type              in_item_ff, in_item_in;
   logic [POS_AW-1:0]         in_paddr_ff;

   // Result stage.
   logic                      out_v_ff;
   logic                      out_kind_ff;
   logic signed [VALUE_W-1:0] out_val_ff;
   logic [POS_CODE_W-1:0]     out_pos_ff;
   logic [1:0]                out_beat_ff;
   logic                      out_last;

   // Position store and its bypass.
   logic [POS_CODE_W-1:0]     pos_mem [2**POS_AW];
   logic [POS_CODE_W-1:0]     pos_rd_ff, pos_wd_ff, pos_rd;
   logic                      pos_byp_ff;

   logic        accept, fwd_acc, bwd_acc, produces, out_free, advance, rsp_xfer;
   logic        pos_we;
   logic [POS_AW-1:0] bwd_addr;
   win_res_type win_res;

   assign accept   = req_chan.valid && req_chan.ready;
   assign fwd_acc  = accept && (req_chan.kind == KIND_FWD);
   assign bwd_acc  = accept && (req_chan.kind == KIND_BWD);
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;
   assign out_last = (out_kind_ff == KIND_FWD) || (out_beat_ff == WP_BOT_RIGHT);
   assign produces = (in_kind_ff == KIND_BWD) ||
                     (in_item_ff.ok && (in_item_ff.wpos == WP_BOT_RIGHT));
   assign out_free = !out_v_ff || (rsp_chan.ready && out_last);
   assign advance  = in_v_ff && (!produces || out_free);
   assign req_chan.ready = !in_v_ff || advance;

   // Forward item decode from the counters at acceptance.
   always_comb begin
      in_item_in.ok = ({1'b0, col_ff} < {cfg.width[DIM_W-1:1], 1'b0}) &&
                      ({1'b0, row_ff} < {cfg.height[DIM_W-1:1], 1'b0});
      in_item_in.wpos  = {row_ff[0], col_ff[0]};
      in_item_in.wcol  = col_ff[COL_W-1:1];
      in_item_in.value = req_chan.value;
   end

   // Counter advance; each counter wraps once it reaches its bound.
   always_comb begin
      logic [COL_W:0]  c_nx;
      logic [ROW_W:0]  r_nx;
      logic [MAP_W:0]  m_nx;
      logic [PCOL_W:0] pc_nx;
      logic [PROW_W:0] pr_nx;
      logic [MAP_W:0]  bm_nx;
      col_in  = col_ff;
      row_in  = row_ff;
      map_in  = map_ff;
      bcol_in = bcol_ff;
      brow_in = brow_ff;
      bmap_in = bmap_ff;
      c_nx  = {1'b0, col_ff} + 1'b1;
      r_nx  = {1'b0, row_ff} + 1'b1;
      m_nx  = {1'b0, map_ff} + 1'b1;
      pc_nx = {1'b0, bcol_ff} + 1'b1;
      pr_nx = {1'b0, brow_ff} + 1'b1;
      bm_nx = {1'b0, bmap_ff} + 1'b1;
      if (fwd_acc) begin
         col_in = c_nx[COL_W-1:0];
         if (DIM_W'(c_nx) >= cfg.width) begin
            col_in = '0;
            row_in = r_nx[ROW_W-1:0];
            if (DIM_W'(r_nx) >= cfg.height) begin
               row_in = '0;
               map_in = m_nx[MAP_W-1:0];
               if (MAPS_W'(m_nx) >= cfg.maps) map_in = '0;
            end
         end
      end
      if (bwd_acc) begin
         bcol_in = pc_nx[PCOL_W-1:0];
         if (DIM_W'(pc_nx) >= pool_w) begin
            bcol_in = '0;
            brow_in = pr_nx[PROW_W-1:0];
            if (DIM_W'(pr_nx) >= pool_h) begin
               brow_in = '0;
               bmap_in = bm_nx[MAP_W-1:0];
               if (MAPS_W'(bm_nx) >= cfg.maps) bmap_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         map_ff  <= '0;
         bcol_ff <= '0;
         brow_ff <= '0;
         bmap_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         map_ff  <= map_in;
         bcol_ff <= bcol_in;
         brow_ff <= brow_in;
         bmap_ff <= bmap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_v_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff  <= req_chan.kind;
         in_item_ff  <= in_item_in;
         in_paddr_ff <= {map_ff, row_ff[ROW_W-1:1], col_ff[COL_W-1:1]};
      end
   end

   mpa_window u_window (
      .clock   (clock),
      .rd_en   (fwd_acc),
      .rd_col  (col_ff[COL_W-1:1]),
      .advance (advance && (in_kind_ff == KIND_FWD)),
      .item    (in_item_ff),
      .res     (win_res)
   );

   // Position store: written when a window completes, read for each error.
   assign pos_we   = advance && (in_kind_ff == KIND_FWD) && in_item_ff.ok &&
                     (in_item_ff.wpos == WP_BOT_RIGHT);
   assign bwd_addr = {bmap_ff, brow_ff, bcol_ff};

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[in_paddr_ff] <= win_res.pos;
      end
   end

   // A window completing in the same cycle as the read is forwarded.
   always_ff @(posedge clock) begin
      if (bwd_acc) begin
         pos_rd_ff  <= pos_mem[bwd_addr];
         pos_byp_ff <= pos_we && (in_paddr_ff == bwd_addr);
         pos_wd_ff  <= win_res.pos;
      end
   end

   assign pos_rd = pos_byp_ff ? pos_wd_ff : pos_rd_ff;

   // Result register; a gradient run steps through the four window positions.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance && produces) begin
         out_v_ff <= 1'b1;
      end else if (rsp_xfer && out_last) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produces) begin
         out_kind_ff <= in_kind_ff;
         out_beat_ff <= WP_TOP_LEFT;
         out_pos_ff  <= pos_rd;
         out_val_ff  <= (in_kind_ff == KIND_FWD) ? win_res.pooled : in_item_ff.value;
      end else if (rsp_xfer) begin
         out_beat_ff <= out_beat_ff + 2'd1;
      end
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.result_kind  = out_kind_ff;
   assign rsp_chan.last_of_run  = out_last;
   assign rsp_chan.result_value =
      ((out_kind_ff == KIND_BWD) && (out_pos_ff != ({1'b0, out_beat_ff} + POS_CODE_W'(1))))
      ? '0 : out_val_ff;

endmodule

/* sv/mpa_csr.sv */
// APB configuration registers with range clamping.
module mpa_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mpa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [mpa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [mpa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output mpa_pkg::cfg_type                cfg
);
   import mpa_pkg::*;

   logic [DIM_W-1:0]     width_ff, height_ff;
   logic [MAPS_W-1:0]    maps_ff;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_MAX;
         height_ff <= HEIGHT_MAX;
         maps_ff   <= MAPS_MIN;
      end else if (wr_en) begin
         case (idx)
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[DIM_W-1:0];
            REG_MAP_COUNT:    maps_ff   <= pwdata[MAPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         REG_MAP_COUNT:    prdata = CSR_DATA_W'(maps_ff);
         default:          prdata = '0;
      endcase
   end

   assign cfg.width  = clamp_dim(width_ff, WIDTH_MAX);
   assign cfg.height = clamp_dim(height_ff, HEIGHT_MAX);
   assign cfg.maps   = clamp_maps(maps_ff);

endmodule

/* sv/mpa_window.sv */
// Running 2x2 window maximum: pair register plus a per-column window memory.
module mpa_window (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [mpa_pkg::PCOL_W-1:0]        rd_col,
   input  logic                              advance,
   input  mpa_pkg::fwd_item_type             item,
   output mpa_pkg::win_res_type              res
);
   import mpa_pkg::*;

   win_entry_type win_mem [HALF_W];
   win_entry_type rd_ff;
   win_entry_type pair_ff, pair_in;
   win_entry_type zero_entry, from_zero, from_pair, final_entry;
   logic          wr_en;

   assign zero_entry = '{maxv: '0, pos: POS_NONE};
   assign from_zero  = win_update(zero_entry, item.value, item.wpos);
   assign from_pair  = win_update(pair_ff, item.value, item.wpos);

   // The bottom row pair beats the stored top row pair only when strictly larger.
   assign final_entry = (from_pair.maxv > rd_ff.maxv) ? from_pair : rd_ff;

   always_comb begin
      pair_in = pair_ff;
      wr_en   = 1'b0;
      case (item.wpos)
         WP_TOP_LEFT, WP_BOT_LEFT: pair_in = from_zero;
         WP_TOP_RIGHT: begin
            pair_in = from_pair;
            wr_en   = 1'b1;
         end
         WP_BOT_RIGHT: wr_en = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance && item.ok) begin
         pair_ff <= pair_in;
      end
   end

   // The top row pair is written at its right sample; the completed window at
   // the bottom right sample.
   always_ff @(posedge clock) begin
      if (advance && item.ok && wr_en) begin
         win_mem[item.wcol] <= (item.wpos == WP_TOP_RIGHT) ? from_pair : final_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= win_mem[rd_col];
      end
   end

   assign res.pos    = final_entry.pos;
   assign res.pooled = final_entry.maxv >>> 1;

endmodule

/* sv/mpa_check.sv */
// Port-level checks of the max pool core, bound to its top level.
`include "max_pool_with_argmax_routing_core_assert.svh"

module mpa_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_kind,
   input logic signed [mpa_pkg::VALUE_W-1:0]  rsp_value,
   input logic                                rsp_last
);
   import mpa_pkg::*;

   // A stalled result keeps its payload.
   `MPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_kind) && $stable(rsp_last))

   // A pooled value always closes its run.
   `MPA_ASSERT_NOW(a_fwd_single, clock, reset, rsp_valid && (rsp_kind == KIND_FWD), rsp_last)

   // A gradient run continues without a gap after each non-final transfer.
   `MPA_ASSERT_NEXT(a_bwd_run, clock, reset, rsp_valid && rsp_ready && (rsp_kind == KIND_BWD) && !rsp_last, rsp_valid && (rsp_kind == KIND_BWD))

   // Reset empties the result register.
   `MPA_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind max_pool_with_argmax_routing_core mpa_check u_mpa_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.result_kind),
   .rsp_value (rsp_chan.result_value),
   .rsp_last  (rsp_chan.last_of_run)
);
